FILE: design/covariance_predict_engine_defines.svh
// Assertion macros shared by the checker of the covariance prediction engine.
`ifndef COVARIANCE_PREDICT_ENGINE_DEFINES_SVH
`define COVARIANCE_PREDICT_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("covariance_predict_engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("covariance_predict_engine check failed");

`endif

FILE: design/cpe_pkg.sv
// Package of the covariance prediction engine: types, constants and saturation helpers.
package cpe_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_DIM_DEF = 4;
  localparam int CFG_IDX_W   = 2;

  // Cycles from the last issued step until its result is readable in memory.
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;

  localparam logic [2:0]        DIM_RESET       = 3'd4;
  localparam logic [DATA_W-1:0] TIME_STEP_RESET = 32'd65536;

  typedef enum logic [1:0] {
    OP_LOAD_F  = 2'd0,
    OP_LOAD_Q  = 2'd1,
    OP_LOAD_P  = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    SEL_FP    = 2'd0,
    SEL_FPFT  = 2'd1,
    SEL_NOISE = 2'd2,
    SEL_EMIT  = 2'd3
  } step_sel_e;

  typedef struct packed {
    logic      issue;
    step_sel_e sel;
    logic      first;
    logic      last;
    logic      clr_sat;
    logic      out_load;
    logic      out_last;
  } cpe_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.hit = 1'b1;
      r.val = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r.hit = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.hit = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/cpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/cpe_ctrl.sv
// Sequencer of the covariance prediction engine: walks the two products and the emission.
module cpe_ctrl import cpe_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [2:0]    dimension_i,
  input  logic          start_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output cpe_cmd_t      cmd_o,
  output logic [IW-1:0] i_o,
  output logic [IW-1:0] j_o,
  output logic [IW-1:0] k_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FP, S_DRAIN1, S_FPFT, S_NOISE, S_DRAIN2, S_ERD, S_ELD, S_EOUT
  } state_e;

  state_e               state_q;
  logic [IW-1:0]        i_q, j_q, k_q;
  logic [DRAIN_W-1:0]   drain_q;
  logic                 out_valid_q;
  logic [IW-1:0]        nm1;
  logic                 last_elem;

  // Out-of-range sizes are folded to the nearest legal one.
  always_comb begin
    if (dimension_i == 3'd0) begin
      nm1 = '0;
    end else if (int'(dimension_i) > MAX_DIM) begin
      nm1 = IW'(MAX_DIM - 1);
    end else begin
      nm1 = IW'(dimension_i - 3'd1);
    end
  end

  assign last_elem = (i_q == nm1) && (j_q == nm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= S_FP;
          end
        end
        S_FP: begin
          if (k_q == nm1) begin
            k_q <= '0;
            if (j_q == nm1) begin
              j_q <= '0;
              if (i_q == nm1) begin
                i_q     <= '0;
                drain_q <= '0;
                state_q <= S_DRAIN1;
              end else begin
                i_q <= IW'(i_q + 1'b1);
              end
            end else begin
              j_q <= IW'(j_q + 1'b1);
            end
          end else begin
            k_q <= IW'(k_q + 1'b1);
          end
        end
        S_DRAIN1: begin
          if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
            drain_q <= '0;
            state_q <= S_FPFT;
          end else begin
            drain_q <= DRAIN_W'(drain_q + 1'b1);
          end
        end
        S_FPFT: begin
          if (k_q == nm1) begin
            k_q     <= '0;
            state_q <= S_NOISE;
          end else begin
            k_q <= IW'(k_q + 1'b1);
          end
        end
        S_NOISE: begin
          state_q <= S_FPFT;
          if (j_q == nm1) begin
            j_q <= '0;
            if (i_q == nm1) begin
              i_q     <= '0;
              drain_q <= '0;
              state_q <= S_DRAIN2;
            end else begin
              i_q <= IW'(i_q + 1'b1);
            end
          end else begin
            j_q <= IW'(j_q + 1'b1);
          end
        end
        S_DRAIN2: begin
          if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
            drain_q <= '0;
            state_q <= S_ERD;
          end else begin
            drain_q <= DRAIN_W'(drain_q + 1'b1);
          end
        end
        S_ERD: begin
          state_q <= S_ELD;
        end
        S_ELD: begin
          out_valid_q <= 1'b1;
          state_q     <= S_EOUT;
        end
        S_EOUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_elem) begin
              i_q     <= '0;
              j_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_ERD;
              if (j_q == nm1) begin
                j_q <= '0;
                i_q <= IW'(i_q + 1'b1);
              end else begin
                j_q <= IW'(j_q + 1'b1);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.sel   = SEL_FP;
    unique case (state_q)
      S_IDLE: cmd_o.clr_sat = start_i;
      S_FP: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (k_q == '0);
        cmd_o.last  = (k_q == nm1);
      end
      S_FPFT: begin
        cmd_o.issue = 1'b1;
        cmd_o.sel   = SEL_FPFT;
        cmd_o.first = (k_q == '0);
      end
      S_NOISE: begin
        cmd_o.issue = 1'b1;
        cmd_o.sel   = SEL_NOISE;
        cmd_o.last  = 1'b1;
      end
      S_ERD, S_ELD: begin
        cmd_o.sel      = SEL_EMIT;
        cmd_o.out_load = (state_q == S_ELD);
        cmd_o.out_last = last_elem;
      end
      default: cmd_o.sel = SEL_FP;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign i_o         = i_q;
  assign j_o         = j_q;
  assign k_o         = k_q;

endmodule

FILE: design/cpe_datapath.sv
// Datapath of the covariance prediction engine: matrix stores, shared multiply-accumulate
// pipeline and output register.
module cpe_datapath import cpe_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int ACC_W = DATA_W + 1 + IW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] time_step_i,
  input  logic              ld_valid_i,
  input  logic [1:0]        ld_opcode_i,
  input  logic [1:0]        ld_row_i,
  input  logic [1:0]        ld_col_i,
  input  logic [DATA_W-1:0] ld_value_i,
  input  cpe_cmd_t          cmd_i,
  input  logic [IW-1:0]     i_i,
  input  logic [IW-1:0]     j_i,
  input  logic [IW-1:0]     k_i,
  output logic [1:0]        out_row_o,
  output logic [1:0]        out_col_o,
  output logic [DATA_W-1:0] out_value_o,
  output logic              saturated_o,
  output logic              last_o
);

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // Load decode.
  logic          ld_in_range;
  logic [AW-1:0] ld_addr;
  logic          ld_f, ld_q, ld_p;

  assign ld_in_range = (int'(ld_row_i) < MAX_DIM) && (int'(ld_col_i) < MAX_DIM);
  assign ld_addr     = addr_of(IW'(ld_row_i), IW'(ld_col_i));
  assign ld_f = ld_valid_i && ld_in_range && (ld_opcode_i == OP_LOAD_F);
  assign ld_q = ld_valid_i && ld_in_range && (ld_opcode_i == OP_LOAD_Q);
  assign ld_p = ld_valid_i && ld_in_range && (ld_opcode_i == OP_LOAD_P);

  // Read address generation.
  logic [AW-1:0] f_raddr, p_raddr, fp_raddr, q_raddr, dest_addr;
  logic [DATA_W-1:0] f_rdata, p_rdata, fp_rdata, q_rdata;

  assign fp_raddr = addr_of(i_i, k_i);
  assign q_raddr  = addr_of(i_i, j_i);
  assign f_raddr  = (cmd_i.sel == SEL_FP) ? addr_of(i_i, k_i) : addr_of(j_i, k_i);
  assign p_raddr  = (cmd_i.sel == SEL_FP) ? addr_of(k_i, j_i) : addr_of(i_i, j_i);
  assign dest_addr = addr_of(i_i, j_i);

  // Write stage.
  logic              wr_en_q;
  logic              wr_to_p_q;
  logic [AW-1:0]     wr_addr_q;
  logic [DATA_W-1:0] wr_data_q;

  cpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_f_ram (
    .clk_i, .we_i(ld_f), .waddr_i(ld_addr), .wdata_i(ld_value_i),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  cpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_q_ram (
    .clk_i, .we_i(ld_q), .waddr_i(ld_addr), .wdata_i(ld_value_i),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  cpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_p_ram (
    .clk_i,
    .we_i   (ld_p || (wr_en_q && wr_to_p_q)),
    .waddr_i(ld_p ? ld_addr : wr_addr_q),
    .wdata_i(ld_p ? ld_value_i : wr_data_q),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  cpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_fp_ram (
    .clk_i, .we_i(wr_en_q && !wr_to_p_q), .waddr_i(wr_addr_q), .wdata_i(wr_data_q),
    .raddr_i(fp_raddr), .rdata_o(fp_rdata)
  );

  // Stage 1: memory data arrives, operands are selected and multiplied.
  logic          s1_valid_q, s1_first_q, s1_last_q;
  step_sel_e     s1_sel_q;
  logic [AW-1:0] s1_dest_q;
  logic signed [DATA_W:0] op_a, op_b;

  always_comb begin
    unique case (s1_sel_q)
      SEL_FP: begin
        op_a = $signed({f_rdata[DATA_W-1], f_rdata});
        op_b = $signed({p_rdata[DATA_W-1], p_rdata});
      end
      SEL_FPFT: begin
        op_a = $signed({fp_rdata[DATA_W-1], fp_rdata});
        op_b = $signed({f_rdata[DATA_W-1], f_rdata});
      end
      default: begin
        op_a = $signed({1'b0, time_step_i});
        op_b = $signed({q_rdata[DATA_W-1], q_rdata});
      end
    endcase
  end

  // Stage 2: product registered, then shifted, saturated and accumulated.
  logic                         s2_valid_q, s2_first_q, s2_last_q;
  step_sel_e                    s2_sel_q;
  logic [AW-1:0]                s2_dest_q;
  logic signed [2*DATA_W+1:0]   prod_q;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic                         sat_q;

  sat_t term, acc_sat, fin_sat;
  logic signed [2*DATA_W-15:0] shifted;
  logic wr_en_d;
  logic [DATA_W-1:0] wr_data_d;
  logic sat_hit;

  assign shifted = prod_q[2*DATA_W+1:16];

  always_comb begin
    term      = sat32(64'(shifted));
    acc_d     = s2_first_q ? ACC_W'($signed(term.val)) : ACC_W'(acc_q + $signed(term.val));
    acc_sat   = sat32(64'(s2_first_q ? acc_d : acc_d));
    fin_sat   = sat32(64'($signed(sat32(64'(acc_q)).val)) + 64'($signed(term.val)));
    wr_en_d   = 1'b0;
    wr_data_d = acc_sat.val;
    sat_hit   = 1'b0;
    if (s2_valid_q) begin
      unique case (s2_sel_q)
        SEL_FP: begin
          wr_en_d = s2_last_q;
          sat_hit = term.hit || (s2_last_q && acc_sat.hit);
        end
        SEL_FPFT: begin
          sat_hit = term.hit;
        end
        default: begin
          wr_en_d   = 1'b1;
          wr_data_d = fin_sat.val;
          sat_hit   = term.hit || sat32(64'(acc_q)).hit || fin_sat.hit;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wr_en_q    <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
      wr_en_q    <= wr_en_d;
      if (cmd_i.clr_sat) begin
        sat_q <= 1'b0;
      end else if (sat_hit) begin
        sat_q <= 1'b1;
      end
    end
  end

  logic [1:0]        out_row_q, out_col_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_sat_q, out_last_q;

  always_ff @(posedge clk_i) begin
    s1_sel_q   <= cmd_i.sel;
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_dest_q  <= dest_addr;
    s2_sel_q   <= s1_sel_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_dest_q  <= s1_dest_q;
    prod_q     <= op_a * op_b;
    if (s2_valid_q && (s2_sel_q != SEL_NOISE)) begin
      acc_q <= acc_d;
    end
    wr_to_p_q <= (s2_sel_q == SEL_NOISE);
    wr_addr_q <= s2_dest_q;
    wr_data_q <= wr_data_d;
    if (cmd_i.out_load) begin
      out_row_q   <= 2'(i_i);
      out_col_q   <= 2'(j_i);
      out_value_q <= p_rdata;
      out_sat_q   <= sat_q;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

endmodule

FILE: design/covariance_predict_engine.sv
// Top level of the covariance prediction engine: configuration registers and the two halves.
//
// The block predicts a Kalman covariance, P <- F*P*F^T + dt*Q, on signed Q16.16 matrices of
// the configured size n. A load item writes one element of F, Q or P; it gives no result. A
// compute item runs F*P into a scratch matrix, then multiplies that by F transposed, adds the
// dt-scaled Q and writes the result back as P, after which every element of the new P leaves
// row by row, the final one marked last. All arithmetic shares one multiplier in an accumulate
// pipeline fed by single-port reads: a compute is accepted, runs n^3 steps for each product
// and one noise step per element, waits for a pipeline drain after each product, and then
// reads, loads and offers each emitted element in turn, holding it until the receiver is
// ready. No new item is taken until the last result transfer of a compute is done. The user
// must write configuration (dimension at index 0, time step at index 1) only while the block
// is idle; the block itself does not enforce this.
module covariance_predict_engine import cpe_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic [1:0]           row_index_i,
  input  logic [1:0]           col_index_i,
  input  logic [DATA_W-1:0]    element_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_row_o,
  output logic [1:0]           out_col_o,
  output logic [DATA_W-1:0]    out_value_o,
  output logic                 saturated_o,
  output logic                 last_o
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [2:0]        dimension_q;
  logic [DATA_W-1:0] time_step_q;

  // Writes to an index beyond the two registers fall through and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimension_q <= DIM_RESET;
      time_step_q <= TIME_STEP_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DIMENSION) begin
        dimension_q <= cfg_data_i[2:0];
      end else if (cfg_index_i == CFG_TIME_STEP) begin
        time_step_q <= cfg_data_i;
      end
    end
  end

  logic          in_xfer;
  cpe_cmd_t      cmd;
  logic [IW-1:0] idx_i, idx_j, idx_k;

  assign in_xfer = in_valid_i && in_ready_o;

  cpe_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i, .rst_ni,
    .dimension_i(dimension_q),
    .start_i    (in_xfer && (opcode_i == OP_COMPUTE)),
    .in_ready_o,
    .out_ready_i,
    .out_valid_o,
    .cmd_o      (cmd),
    .i_o        (idx_i),
    .j_o        (idx_j),
    .k_o        (idx_k)
  );

  cpe_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk_i, .rst_ni,
    .time_step_i(time_step_q),
    .ld_valid_i (in_xfer && (opcode_i != OP_COMPUTE)),
    .ld_opcode_i(opcode_i),
    .ld_row_i   (row_index_i),
    .ld_col_i   (col_index_i),
    .ld_value_i (element_value_i),
    .cmd_i      (cmd),
    .i_i        (idx_i),
    .j_i        (idx_j),
    .k_i        (idx_k),
    .out_row_o, .out_col_o, .out_value_o, .saturated_o, .last_o
  );

endmodule

FILE: design/cpe_checker.sv
// Port-level checker of the covariance prediction engine and its bind.
`include "covariance_predict_engine_defines.svh"

module cpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  out_row_o,
  input logic [1:0]  out_col_o,
  input logic [31:0] out_value_o,
  input logic        saturated_o,
  input logic        last_o
);

  // A result held back by the receiver keeps its contents.
  `CPE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_value_o) && $stable(last_o) && $stable(out_row_o) && $stable(out_col_o) && $stable(saturated_o))

  // No new item is taken while a result is on offer.
  `CPE_ASSERT_SAME(a_busy_emit, out_valid_o, !in_ready_o)

  // The final transfer of a compute returns the block to idle.
  `CPE_ASSERT_NEXT(a_last_idle, out_valid_o && out_ready_i && last_o,
                   !out_valid_o && in_ready_o)

endmodule

bind covariance_predict_engine cpe_checker u_cpe_checker (.*);
